// ===== hw/rtl/dsoq_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth-sorted occluder queue package
// Shared types and constants: opcodes, beat payloads, the stored entry and FSM states.
// ----------------------------------------------------------------------------
package dsoq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int COORD_BITS   = 16;
    localparam int DEPTH_BITS   = 32;
    localparam int HANDLE_BITS  = 16;
    localparam int COUNT_BITS   = 6;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_POINT  = 2'd2,
        OP_FETCH  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                        opcode;
        logic signed [COORD_BITS-1:0]   box_min_x;
        logic signed [COORD_BITS-1:0]   box_min_y;
        logic signed [COORD_BITS-1:0]   box_max_x;
        logic signed [COORD_BITS-1:0]   box_max_y;
        logic signed [COORD_BITS-1:0]   point_x;
        logic signed [COORD_BITS-1:0]   point_y;
        logic signed [DEPTH_BITS-1:0]   item_depth;
        logic        [HANDLE_BITS-1:0]  object_handle;
    } t_in_item;

    typedef struct packed {
        logic                           found;
        logic        [HANDLE_BITS-1:0]  found_handle;
        logic signed [DEPTH_BITS-1:0]   found_depth;
        logic                           dropped_full;
        logic        [COUNT_BITS-1:0]   entry_count;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]   min_x;
        logic signed [COORD_BITS-1:0]   min_y;
        logic signed [COORD_BITS-1:0]   max_x;
        logic signed [COORD_BITS-1:0]   max_y;
        logic signed [DEPTH_BITS-1:0]   depth;
        logic        [HANDLE_BITS-1:0]  handle;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP_RD,
        ST_APP_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } t_state;

endpackage

// ===== hw/rtl/depth_sorted_occluder_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Depth-sorted occluder queue
// Keeps occluder boxes sorted by depth in a one-write, one-read entry memory and
// answers point and box-overlap queries by walking it with one compare unit.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------
//  in      | input     | i_in_valid / o_in_stall | t_in_item
//  out     | output    | o_out_valid/ i_out_stall| t_out_item
//
// A clear or a refused append is answered from ST_IDLE. An append moves deeper
// entries up one slot from the tail (ST_APP_RD, ST_APP_WR) until slot 0 or an
// entry that is not deeper; a query alternates ST_SCAN_RD and ST_SCAN_CHK to the
// tail, a deeper entry or a hit; a fetch hit then closes the gap (ST_SHIFT_RD,
// ST_SHIFT_WR). Input stalls outside ST_IDLE. Reset empties the queue without
// clearing memory. A stalled result beat holds and blocks the next input beat.
// ----------------------------------------------------------------------------
module depth_sorted_occluder_queue_unit #(
    parameter int CAPACITY = dsoq_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dsoq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dsoq_pkg::t_out_item o_out_data
);
    import dsoq_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;

    t_entry             r_mem [CAPACITY];
    t_entry             r_rd_data;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [CNT_W-1:0]   r_idx, n_idx;
    t_in_item           r_req, n_req;
    t_entry             r_hit, n_hit;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [ADDR_W-1:0]  mem_ra;
    t_entry             mem_wd;

    logic               accept;
    logic [CNT_W-1:0]   idx_m1;
    logic [CNT_W-1:0]   idx_p1;
    logic [WIDE_W-1:0]  cnt_wide;
    t_entry             new_entry;

    // Shared compare unit: depth limit plus the closed box test. For a point
    // query both x operands are the point; for a fetch they are the box edges.
    logic signed [COORD_BITS-1:0] cmp_ax, cmp_bx, cmp_ay, cmp_by;
    logic               cmp_deeper;
    logic               cmp_hit;

    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign idx_m1 = r_idx - CNT_W'(1);
    assign idx_p1 = r_idx + CNT_W'(1);

    assign new_entry.min_x  = r_req.box_min_x;
    assign new_entry.min_y  = r_req.box_min_y;
    assign new_entry.max_x  = r_req.box_max_x;
    assign new_entry.max_y  = r_req.box_max_y;
    assign new_entry.depth  = r_req.item_depth;
    assign new_entry.handle = r_req.object_handle;

    always_comb begin
        if (r_req.opcode == OP_POINT) begin
            cmp_ax = r_req.point_x;
            cmp_bx = r_req.point_x;
            cmp_ay = r_req.point_y;
            cmp_by = r_req.point_y;
        end else begin
            cmp_ax = r_req.box_max_x;
            cmp_bx = r_req.box_min_x;
            cmp_ay = r_req.box_max_y;
            cmp_by = r_req.box_min_y;
        end
        cmp_deeper = r_rd_data.depth > r_req.item_depth;
        cmp_hit    = (r_rd_data.min_x <= cmp_ax) && (cmp_bx <= r_rd_data.max_x) &&
                     (r_rd_data.min_y <= cmp_ay) && (cmp_by <= r_rd_data.max_y);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
        r_idx <= n_idx;
        r_req <= n_req;
        r_hit <= n_hit;
        r_out <= n_out;
    end

    always_comb begin
        logic       done;
        logic       res_found;
        logic       res_dropped;
        logic       res_fetched;

        n_state     = r_state;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_req       = r_req;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wa      = r_idx[ADDR_W-1:0];
        mem_wd      = new_entry;
        mem_ra      = r_idx[ADDR_W-1:0];
        done        = 1'b0;
        res_found   = 1'b0;
        res_dropped = 1'b0;
        res_fetched = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req = i_in_data;
                    case (i_in_data.opcode)
                        OP_CLEAR: begin
                            n_occ = '0;
                            done  = 1'b1;
                        end
                        OP_APPEND: begin
                            if (r_occ >= CNT_W'(CAPACITY)) begin
                                res_dropped = 1'b1;
                                done        = 1'b1;
                            end else begin
                                n_idx   = r_occ;
                                n_state = ST_APP_RD;
                            end
                        end
                        default: begin
                            n_idx   = '0;
                            n_state = ST_SCAN_RD;
                        end
                    endcase
                end
            end

            // Walk down from the tail, moving deeper entries up one slot.
            ST_APP_RD: begin
                if (r_idx == '0) begin
                    mem_we = 1'b1;
                    n_occ  = r_occ + CNT_W'(1);
                    done   = 1'b1;
                end else begin
                    mem_ra  = idx_m1[ADDR_W-1:0];
                    n_state = ST_APP_WR;
                end
            end

            ST_APP_WR: begin
                mem_we = 1'b1;
                if (cmp_deeper) begin
                    mem_wd  = r_rd_data;
                    n_idx   = idx_m1;
                    n_state = ST_APP_RD;
                end else begin
                    n_occ = r_occ + CNT_W'(1);
                    done  = 1'b1;
                end
            end

            ST_SCAN_RD: begin
                if (r_idx == r_occ) begin
                    done = 1'b1;
                end else begin
                    n_state = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK: begin
                if (cmp_deeper) begin
                    done = 1'b1;
                end else if (cmp_hit) begin
                    if (r_req.opcode == OP_POINT) begin
                        res_found = 1'b1;
                        done      = 1'b1;
                    end else begin
                        n_hit   = r_rd_data;
                        n_state = ST_SHIFT_RD;
                    end
                end else begin
                    n_idx   = idx_p1;
                    n_state = ST_SCAN_RD;
                end
            end

            // Close the gap left by the fetched entry.
            ST_SHIFT_RD: begin
                if (idx_p1 >= r_occ) begin
                    n_occ       = r_occ - CNT_W'(1);
                    res_found   = 1'b1;
                    res_fetched = 1'b1;
                    done        = 1'b1;
                end else begin
                    mem_ra  = idx_p1[ADDR_W-1:0];
                    n_state = ST_SHIFT_WR;
                end
            end

            ST_SHIFT_WR: begin
                mem_we  = 1'b1;
                mem_wd  = r_rd_data;
                n_idx   = idx_p1;
                n_state = ST_SHIFT_RD;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        cnt_wide = WIDE_W'(n_occ);
        if (done) begin
            n_state            = ST_IDLE;
            n_out_valid        = 1'b1;
            n_out.found        = res_found;
            n_out.found_handle = res_fetched ? r_hit.handle : '0;
            n_out.found_depth  = res_fetched ? r_hit.depth : '0;
            n_out.dropped_full = res_dropped;
            n_out.entry_count  = cnt_wide[COUNT_BITS-1:0];
        end
    end

endmodule

// ===== tb/sv/depth_sorted_occluder_queue_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Occluder queue result checker
// Watches both channels of the depth-sorted occluder queue, keeps its own
// sorted copy of the entries, works out the result of every accepted input
// beat and compares each accepted result beat, field by field, in order.
// ----------------------------------------------------------------------------
module depth_sorted_occluder_queue_unit_checker #(
    parameter int CAPACITY = dsoq_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  dsoq_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  dsoq_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import dsoq_pkg::*;

    t_entry      occluders[CAPACITY];
    int unsigned occluder_count;
    t_out_item   awaited_results[$];
    int          fail_total;

    // Applies one operation to the local copy of the queue and returns its result.
    task automatic apply_op(input t_in_item beat, output t_out_item res);
        int unsigned i;
        int unsigned k;
        int unsigned pos;
        t_entry      e;
        res = '0;
        case (beat.opcode)
            OP_CLEAR: begin
                occluder_count = 0;
            end
            OP_APPEND: begin
                if (occluder_count >= CAPACITY) begin
                    res.dropped_full = 1'b1;
                end else begin
                    // Equal depths keep arrival order: insert before the first deeper entry.
                    pos = occluder_count;
                    for (i = 0; i < occluder_count; i++) begin
                        if (occluders[i].depth > beat.item_depth) begin
                            pos = i;
                            break;
                        end
                    end
                    for (k = occluder_count; k > pos; k--) occluders[k] = occluders[k-1];
                    e.min_x  = beat.box_min_x;
                    e.min_y  = beat.box_min_y;
                    e.max_x  = beat.box_max_x;
                    e.max_y  = beat.box_max_y;
                    e.depth  = beat.item_depth;
                    e.handle = beat.object_handle;
                    occluders[pos] = e;
                    occluder_count++;
                end
            end
            OP_POINT: begin
                for (i = 0; i < occluder_count; i++) begin
                    e = occluders[i];
                    if (e.depth > beat.item_depth) break;
                    if (e.min_x <= beat.point_x && beat.point_x <= e.max_x &&
                        e.min_y <= beat.point_y && beat.point_y <= e.max_y) begin
                        res.found = 1'b1;
                        break;
                    end
                end
            end
            OP_FETCH: begin
                for (i = 0; i < occluder_count; i++) begin
                    e = occluders[i];
                    if (e.depth > beat.item_depth) break;
                    if (e.min_x <= beat.box_max_x && beat.box_min_x <= e.max_x &&
                        e.min_y <= beat.box_max_y && beat.box_min_y <= e.max_y) begin
                        res.found        = 1'b1;
                        res.found_handle = e.handle;
                        res.found_depth  = e.depth;
                        for (k = i; k + 1 < occluder_count; k++) occluders[k] = occluders[k+1];
                        occluder_count--;
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = COUNT_BITS'(occluder_count);
    endtask

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            awaited_results.delete();
            occluder_count = 0;
            fail_total     = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h", $time,
                             i_out_data);
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    fail_total += field_diff("found", want.found, i_out_data.found);
                    fail_total += field_diff("found_handle", want.found_handle,
                                             i_out_data.found_handle);
                    fail_total += field_diff("found_depth", want.found_depth,
                                             i_out_data.found_depth);
                    fail_total += field_diff("dropped_full", want.dropped_full,
                                             i_out_data.dropped_full);
                    fail_total += field_diff("entry_count", want.entry_count,
                                             i_out_data.entry_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_op(i_in_data, want);
                awaited_results.push_back(want);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== tb/sv/depth_sorted_occluder_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Occluder queue testbench
// Drives directed and random operation beats into the depth-sorted occluder
// queue under varying idle and stall patterns; the checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module depth_sorted_occluder_queue_unit_tb;
    import dsoq_pkg::*;

    localparam int ITEMS          = 1700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int DRAIN_CYCLES   = 200;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;

    int  send_idle   = 36;
    int  recv_idle   = 79;
    bit  pressure_go = 1'b0;
    bit  pressure_done = 1'b0;
    int  hold_left   = 0;
    int  sent        = 0;
    int  phase       = 1;
    int  idle_run    = 0;
    int  op_seen[4]  = '{0, 0, 0, 0};
    int  result_total = 0;
    int  drop_total  = 0;
    int  hit_total   = 0;
    int  peak_fill   = 0;

    always #4 clk = ~clk;

    depth_sorted_occluder_queue_unit #(
        .CAPACITY(CAPACITY_DEF)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    depth_sorted_occluder_queue_unit_checker #(
        .CAPACITY(CAPACITY_DEF)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: random stalls, plus one long hold-off once the last phase starts.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (pressure_go && !pressure_done) begin
            out_stall     <= 1'b1;
            hold_left     <= PRESSURE_HOLD;
            pressure_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Watchdog on beat traffic, plus a few statistics for the summary.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
        else idle_run++;
        if (out_valid && !out_stall) begin
            result_total++;
            if (out_data.dropped_full) drop_total++;
            if (out_data.found) hit_total++;
            if (int'(out_data.entry_count) > peak_fill) peak_fill = int'(out_data.entry_count);
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_in_item beat_of(t_opcode op, int bx0, int by0, int bx1, int by1,
                                         int px, int py, int dep, int hnd);
        t_in_item b;
        b.opcode        = op;
        b.box_min_x     = 16'(bx0);
        b.box_min_y     = 16'(by0);
        b.box_max_x     = 16'(bx1);
        b.box_max_y     = 16'(by1);
        b.point_x       = 16'(px);
        b.point_y       = 16'(py);
        b.item_depth    = 32'(dep);
        b.object_handle = 16'(hnd);
        return b;
    endfunction

    // Narrow beats crowd boxes, points and depths together so that hits and
    // equal depths are common; wide beats use the full range of every field.
    function automatic t_in_item make_beat(t_opcode op, bit wide);
        t_in_item b;
        int       x0;
        int       y0;
        if (wide) begin
            b.box_min_x  = 16'($urandom);
            b.box_min_y  = 16'($urandom);
            b.box_max_x  = 16'($urandom);
            b.box_max_y  = 16'($urandom);
            b.point_x    = 16'($urandom);
            b.point_y    = 16'($urandom);
            b.item_depth = 32'($urandom);
        end else begin
            x0 = int'($urandom_range(0, 200)) - 100;
            y0 = int'($urandom_range(0, 200)) - 100;
            b.box_min_x  = 16'(x0);
            b.box_min_y  = 16'(y0);
            b.box_max_x  = 16'(x0 + int'($urandom_range(0, 70)) - 6);
            b.box_max_y  = 16'(y0 + int'($urandom_range(0, 70)) - 6);
            b.point_x    = 16'(int'($urandom_range(0, 280)) - 140);
            b.point_y    = 16'(int'($urandom_range(0, 280)) - 140);
            if ($urandom_range(0, 7) == 0) b.item_depth = 32'sh7fff_ffff;
            else b.item_depth = 32'(int'($urandom_range(0, 16)) - 8);
        end
        b.opcode        = op;
        b.object_handle = 16'($urandom);
        return b;
    endfunction

    function automatic t_opcode pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return OP_CLEAR;
        if (r < 45) return OP_APPEND;
        if (r < 65) return OP_POINT;
        return OP_FETCH;
    endfunction

    task automatic send_beat(input t_in_item beat);
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        op_seen[int'(beat.opcode)]++;
        do @(posedge clk); while (in_stall);
    endtask

    // Random beats go through here so that the idle pattern follows the count.
    task automatic issue(input t_in_item beat);
        if (phase == 1 && sent >= ITEMS / 3) begin
            phase = 2;
            send_idle = 79;
            recv_idle <= 36;
        end else if (phase == 2 && sent >= 2 * ITEMS / 3) begin
            phase = 3;
            send_idle = 0;
            recv_idle   <= 0;
            pressure_go <= 1'b1;
        end
        send_beat(beat);
        sent++;
    endtask

    initial begin : stimulus
        int n;
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, then five entries covering extreme depths, equal
        // depths, an inverted box and a full-range box.
        send_beat(beat_of(OP_POINT, 0, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 0));
        send_beat(beat_of(OP_FETCH, -32768, -32768, 32767, 32767, 0, 0, 32'sh7fff_ffff, 0));
        send_beat(beat_of(OP_APPEND, 10, 10, 10, 10, 0, 0, 32'sh8000_0000, 0));
        send_beat(beat_of(OP_APPEND, 0, 0, 100, 100, 0, 0, 5, 1));
        send_beat(beat_of(OP_APPEND, 0, 0, 100, 100, 0, 0, 5, 2));
        send_beat(beat_of(OP_APPEND, 50, 50, -50, -50, 0, 0, 3, 3));
        send_beat(beat_of(OP_APPEND, -32768, -32768, 32767, 32767, 0, 0, 32'sh7fff_ffff,
                          65535));
        // Point queries on closed bounds and against the depth limit.
        send_beat(beat_of(OP_POINT, 0, 0, 0, 0, 100, 100, 4, 0));
        send_beat(beat_of(OP_POINT, 0, 0, 0, 0, 100, 100, 5, 0));
        send_beat(beat_of(OP_POINT, 0, 0, 0, 0, 101, 100, 5, 0));
        send_beat(beat_of(OP_POINT, 0, 0, 0, 0, 10, 10, 32'sh8000_0000, 0));
        send_beat(beat_of(OP_POINT, 0, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 0));
        // Fetches: corner touch picks the earlier of two equal depths,
        // an inverted query box misses, the depth limit cuts the scan.
        send_beat(beat_of(OP_FETCH, 100, 100, 200, 200, 0, 0, 5, 0));
        send_beat(beat_of(OP_FETCH, 200, 200, 100, 100, 0, 0, 5, 0));
        send_beat(beat_of(OP_FETCH, -5, -5, -1, -1, 0, 0, 4, 0));
        send_beat(beat_of(OP_FETCH, 0, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 0));
        send_beat(beat_of(OP_FETCH, 10, 10, 10, 10, 0, 0, 32'sh8000_0000, 0));
        send_beat(beat_of(OP_CLEAR, 1, 2, 3, 4, 5, 6, 7, 8));
        send_beat(beat_of(OP_POINT, -32768, -32768, 32767, 32767, 0, 0, 32'sh7fff_ffff, 0));
        send_beat(beat_of(OP_APPEND, -32768, -32768, -32768, -32768, 0, 0, 32'sh7fff_ffff,
                          65535));
        send_beat(beat_of(OP_FETCH, -32768, -32768, -32768, -32768, 0, 0, 32'sh7fff_ffff, 0));

        // Start the random part by filling the queue past its capacity.
        issue(make_beat(OP_CLEAR, 1'b0));
        repeat (36) issue(make_beat(OP_APPEND, 1'b0));

        while (sent < ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                n = $urandom_range(30, 38);
                repeat (n) issue(make_beat(OP_APPEND, 1'b0));
            end else if (r < 18) begin
                n = $urandom_range(1, 6);
                repeat (n) issue(make_beat(t_opcode'($urandom_range(0, 3)), 1'b1));
            end else begin
                n = $urandom_range(10, 30);
                repeat (n) issue(make_beat(pick_op(), 1'b0));
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d beats sent (clear %0d, append %0d, point %0d, fetch %0d)",
                 sent + 21, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
        $display("tb: %0d results, %0d hits, %0d refused appends, peak occupancy %0d",
                 result_total, hit_total, drop_total, peak_fill);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dsoq_pkg.sv
hw/rtl/depth_sorted_occluder_queue_unit.sv
tb/sv/depth_sorted_occluder_queue_unit_checker.sv
tb/sv/depth_sorted_occluder_queue_unit_tb.sv
